>>> hw/rtl/ycr_pkg.sv
// ycr_pkg: shared types, constants and helpers of the yuyv crop to rgb converter
// no dependencies; imported by every module of the block

package ycr_pkg;

   typedef struct packed {
      logic [7:0] luma_first;
      logic [7:0] chroma_blue;
      logic [7:0] luma_second;
      logic [7:0] chroma_red;
      logic       frame_start;
   } req_word_type;

   typedef struct packed {
      logic [7:0] red_first;
      logic [7:0] green_first;
      logic [7:0] blue_first;
      logic [7:0] red_second;
      logic [7:0] green_second;
      logic [7:0] blue_second;
      logic       line_end;
      logic       frame_end;
   } rsp_word_type;

   typedef struct packed {
      logic [12:0] frame_width;
      logic [11:0] crop_left;
      logic [11:0] crop_top;
      logic [12:0] crop_width;
      logic [12:0] crop_height;
   } cfg_type;

   typedef struct packed {
      logic line_end;
      logic frame_end;
   } flags_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_en_type;

   typedef struct packed {
      logic       sat;
      logic [7:0] q;
   } chan_type;

   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
   } pixel_type;

   typedef struct packed {
      logic        sat;
      logic [17:0] level;
   } clip_type;

   typedef enum logic [2:0] {
      REG_FRAME_WIDTH = 3'd0,
      REG_CROP_LEFT   = 3'd1,
      REG_CROP_TOP    = 3'd2,
      REG_CROP_WIDTH  = 3'd3,
      REG_CROP_HEIGHT = 3'd4
   } reg_index_type;

   localparam int ADDR_W = 5;

   localparam logic [12:0] RST_FRAME_WIDTH = 13'd640;
   localparam logic [11:0] RST_CROP_LEFT   = 12'd80;
   localparam logic [11:0] RST_CROP_TOP    = 12'd0;
   localparam logic [12:0] RST_CROP_WIDTH  = 13'd480;
   localparam logic [12:0] RST_CROP_HEIGHT = 13'd480;

   localparam logic signed [11:0] COEF_Y  = 12'sd1164;
   localparam logic signed [11:0] COEF_RV = 12'sd1596;
   localparam logic signed [11:0] COEF_GU = 12'sd392;
   localparam logic signed [11:0] COEF_GV = 12'sd813;
   localparam logic signed [11:0] COEF_BU = 12'sd2017;

   localparam logic signed [9:0]  LUMA_OFFSET   = 10'sd16;
   localparam logic signed [8:0]  CHROMA_OFFSET = 9'sd128;

   localparam logic signed [20:0] CLAMP_LOW = 21'sd999;
   localparam logic signed [20:0] SAT_LIMIT = 21'sd256000;

   // floor(c / 1000) == (c * RECIP) >> RECIP_SHIFT for c below 256000
   localparam logic [18:0] RECIP       = 19'd268436;
   localparam int          RECIP_SHIFT = 28;

   localparam logic [7:0] CHAN_MAX = 8'd255;

   function automatic clip_type clip_level(input logic signed [20:0] sum);
      clip_type c;
      c.sat = (sum >= SAT_LIMIT);
      if (sum < CLAMP_LOW) begin
         c.level = CLAMP_LOW[17:0];
      end else begin
         c.level = sum[17:0];
      end
      return c;
   endfunction

endpackage

>>> hw/rtl/ycr_window.sv
// ycr_window: raster position counters and crop window decision per macropixel
// depends on ycr_pkg

module ycr_window #(
   parameter int MAX_FRAME_WIDTH  = 4096,
   parameter int MAX_FRAME_HEIGHT = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              frame_start,
   input  ycr_pkg::cfg_type  cfg,
   output logic              kept,
   output ycr_pkg::flags_type flags
);
   import ycr_pkg::*;

   localparam int LINE_LIM = (MAX_FRAME_WIDTH / 2 > 2048) ? 2048 : MAX_FRAME_WIDTH / 2;
   localparam int COL_W    = $clog2(LINE_LIM);
   localparam int ROW_MAX  = ((MAX_FRAME_HEIGHT > 4096) ? 4096 : MAX_FRAME_HEIGHT) - 1;
   localparam int ROW_W    = $clog2(ROW_MAX + 1);

   logic [COL_W-1:0] column_ff, column_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic [COL_W-1:0] col_cur;
   logic [ROW_W-1:0] row_cur;
   logic [11:0]      half_width, per_line, col_wide, col_eff;
   logic             last_in_line;
   logic [13:0]      x, left, right, row_w, top, bottom;

   always_comb begin
      half_width = cfg.frame_width[12:1];
      if (half_width > 12'(LINE_LIM)) begin
         per_line = 12'(LINE_LIM);
      end else if (half_width == 12'd0) begin
         per_line = 12'd1;
      end else begin
         per_line = half_width;
      end

      col_cur  = frame_start ? '0 : column_ff;
      row_cur  = frame_start ? '0 : row_ff;
      col_wide = 12'(col_cur);
      col_eff  = (col_wide >= per_line) ? per_line - 12'd1 : col_wide;
      last_in_line = (col_eff == per_line - 12'd1);

      x      = 14'({col_eff, 1'b0});
      left   = 14'({cfg.crop_left[11:1], 1'b0});
      right  = left + 14'({cfg.crop_width[12:1], 1'b0});
      row_w  = 14'(row_cur);
      top    = 14'(cfg.crop_top);
      bottom = top + 14'(cfg.crop_height);

      kept = (row_w >= top) && (row_w < bottom) && (x >= left) && (x + 14'd2 <= right);
      flags.line_end  = (x + 14'd2 == right) || last_in_line;
      flags.frame_end = flags.line_end && (row_w == bottom - 14'd1);

      column_in = column_ff;
      row_in    = row_ff;
      if (accept) begin
         if (last_in_line) begin
            column_in = '0;
            row_in    = (row_cur < ROW_W'(ROW_MAX)) ? row_cur + 1'b1 : row_cur;
         end else begin
            column_in = COL_W'(col_eff + 12'd1);
            row_in    = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

endmodule

>>> hw/rtl/ycr_lane.sv
// ycr_lane: three-stage ycbcr to rgb conversion of one pixel
// depends on ycr_pkg

module ycr_lane (
   input  logic                  clock,
   input  ycr_pkg::stage_en_type en,
   input  logic [7:0]            luma,
   input  logic [7:0]            chroma_blue,
   input  logic [7:0]            chroma_red,
   output ycr_pkg::pixel_type    pixel
);
   import ycr_pkg::*;

   logic signed [9:0]  y_s;
   logic signed [8:0]  u_s, v_s;
   logic signed [20:0] py_ff, pvr_ff, pug_ff, pvg_ff, pub_ff;
   logic signed [20:0] py_in, pvr_in, pug_in, pvg_in, pub_in;
   logic signed [20:0] sum_r, sum_g, sum_b;
   clip_type           clip_ff [3];
   clip_type           clip_in [3];
   logic [36:0]        recip [3];
   logic [7:0]         q_ff [3];
   logic               sat_ff [3];

   always_comb begin
      y_s = $signed({2'b00, luma}) - LUMA_OFFSET;
      u_s = $signed({1'b0, chroma_blue}) - CHROMA_OFFSET;
      v_s = $signed({1'b0, chroma_red}) - CHROMA_OFFSET;
      py_in  = 21'(y_s * COEF_Y);
      pvr_in = 21'(v_s * COEF_RV);
      pug_in = 21'(u_s * COEF_GU);
      pvg_in = 21'(v_s * COEF_GV);
      pub_in = 21'(u_s * COEF_BU);

      sum_r = py_ff + pvr_ff;
      sum_g = py_ff - pug_ff - pvg_ff;
      sum_b = py_ff + pub_ff;
      clip_in[0] = clip_level(sum_r);
      clip_in[1] = clip_level(sum_g);
      clip_in[2] = clip_level(sum_b);

      for (int i = 0; i < 3; i++) begin
         recip[i] = 37'(clip_ff[i].level) * 37'(RECIP);
      end
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         py_ff  <= py_in;
         pvr_ff <= pvr_in;
         pug_ff <= pug_in;
         pvg_ff <= pvg_in;
         pub_ff <= pub_in;
      end
      if (en.s2) begin
         for (int i = 0; i < 3; i++) begin
            clip_ff[i] <= clip_in[i];
         end
      end
      if (en.s3) begin
         for (int i = 0; i < 3; i++) begin
            q_ff[i]   <= recip[i][RECIP_SHIFT +: 8];
            sat_ff[i] <= clip_ff[i].sat;
         end
      end
   end

   assign pixel.red   = '{sat: sat_ff[0], q: q_ff[0]};
   assign pixel.green = '{sat: sat_ff[1], q: q_ff[1]};
   assign pixel.blue  = '{sat: sat_ff[2], q: q_ff[2]};

endmodule

>>> hw/rtl/ycr_merge.sv
// ycr_merge: joins both lanes and the window flags into the output word register
// depends on ycr_pkg

module ycr_merge (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   valid_in,
   input  ycr_pkg::flags_type     flags,
   input  ycr_pkg::pixel_type     pixel_first,
   input  ycr_pkg::pixel_type     pixel_second,
   input  logic                   rsp_stall,
   output logic                   ready,
   output logic                   rsp_valid,
   output ycr_pkg::rsp_word_type  rsp_data
);
   import ycr_pkg::*;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_data_ff, rsp_data_in;

   function automatic logic [7:0] chan_byte(input chan_type c);
      return c.sat ? CHAN_MAX : c.q;
   endfunction

   always_comb begin
      ready        = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = ready ? valid_in : rsp_valid_ff;
      rsp_data_in.red_first    = chan_byte(pixel_first.red);
      rsp_data_in.green_first  = chan_byte(pixel_first.green);
      rsp_data_in.blue_first   = chan_byte(pixel_first.blue);
      rsp_data_in.red_second   = chan_byte(pixel_second.red);
      rsp_data_in.green_second = chan_byte(pixel_second.green);
      rsp_data_in.blue_second  = chan_byte(pixel_second.blue);
      rsp_data_in.line_end     = flags.line_end;
      rsp_data_in.frame_end    = flags.frame_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> hw/rtl/yuyv_crop_to_rgb_core.sv
// yuyv_crop_to_rgb_core: top level, config registers, window, two pixel lanes and merge
// depends on ycr_pkg, ycr_window, ycr_lane, ycr_merge

// Takes one YUYV macropixel per clock and returns two RGB pixels per macropixel that falls
// inside the crop window; macropixels outside the window are consumed and give no word.
// A kept macropixel passes three conversion stages, run in step by both pixel lanes, and then
// the output register that drives rsp_valid. Sustained rate is 1 macropixel per clock;
// req_stall rises only when every stage holds a word and the output is stalled.
// Crop and frame width registers are written over the APB port; the user must write them
// only while the stream is idle, which the block itself does not enforce.

module yuyv_crop_to_rgb_core #(
   parameter int MAX_FRAME_WIDTH  = 4096,
   parameter int MAX_FRAME_HEIGHT = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  ycr_pkg::req_word_type         req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output ycr_pkg::rsp_word_type         rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ycr_pkg::ADDR_W-1:0]    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import ycr_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type reg_index;
   logic          cfg_write;

   logic          accept, kept;
   flags_type     win_flags;
   logic          v1_ff, v2_ff, v3_ff, v1_in, v2_in, v3_in;
   flags_type     flags1_ff, flags2_ff, flags3_ff;
   logic          adv0, adv1, adv2, merge_ready;
   stage_en_type  en;
   pixel_type     pixel_first, pixel_second;

   assign pready    = 1'b1;
   assign reg_index = reg_index_type'(paddr[ADDR_W-1:2]);
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         case (reg_index)
            REG_FRAME_WIDTH: cfg_in.frame_width = pwdata[12:0];
            REG_CROP_LEFT:   cfg_in.crop_left   = pwdata[11:0];
            REG_CROP_TOP:    cfg_in.crop_top    = pwdata[11:0];
            REG_CROP_WIDTH:  cfg_in.crop_width  = pwdata[12:0];
            REG_CROP_HEIGHT: cfg_in.crop_height = pwdata[12:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
      case (reg_index)
         REG_FRAME_WIDTH: prdata = 32'(cfg_ff.frame_width);
         REG_CROP_LEFT:   prdata = 32'(cfg_ff.crop_left);
         REG_CROP_TOP:    prdata = 32'(cfg_ff.crop_top);
         REG_CROP_WIDTH:  prdata = 32'(cfg_ff.crop_width);
         REG_CROP_HEIGHT: prdata = 32'(cfg_ff.crop_height);
         default:         prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width <= RST_FRAME_WIDTH;
         cfg_ff.crop_left   <= RST_CROP_LEFT;
         cfg_ff.crop_top    <= RST_CROP_TOP;
         cfg_ff.crop_width  <= RST_CROP_WIDTH;
         cfg_ff.crop_height <= RST_CROP_HEIGHT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // stage advance chain, each stage moves when the next one is empty or moving
   always_comb begin
      adv2 = !v3_ff || merge_ready;
      adv1 = !v2_ff || adv2;
      adv0 = !v1_ff || adv1;
      en   = '{s1: adv0, s2: adv1, s3: adv2};
      req_stall = !adv0;
      accept    = req_valid && !req_stall;
      v1_in = adv0 ? accept && kept : v1_ff;
      v2_in = adv1 ? v1_ff : v2_ff;
      v3_in = adv2 ? v2_ff : v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv0) begin
         flags1_ff <= win_flags;
      end
      if (adv1) begin
         flags2_ff <= flags1_ff;
      end
      if (adv2) begin
         flags3_ff <= flags2_ff;
      end
   end

   ycr_window #(
      .MAX_FRAME_WIDTH  (MAX_FRAME_WIDTH),
      .MAX_FRAME_HEIGHT (MAX_FRAME_HEIGHT)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .frame_start (req_data.frame_start),
      .cfg         (cfg_ff),
      .kept        (kept),
      .flags       (win_flags)
   );

   ycr_lane u_lane_first (
      .clock       (clock),
      .en          (en),
      .luma        (req_data.luma_first),
      .chroma_blue (req_data.chroma_blue),
      .chroma_red  (req_data.chroma_red),
      .pixel       (pixel_first)
   );

   ycr_lane u_lane_second (
      .clock       (clock),
      .en          (en),
      .luma        (req_data.luma_second),
      .chroma_blue (req_data.chroma_blue),
      .chroma_red  (req_data.chroma_red),
      .pixel       (pixel_second)
   );

   ycr_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .valid_in     (v3_ff),
      .flags        (flags3_ff),
      .pixel_first  (pixel_first),
      .pixel_second (pixel_second),
      .rsp_stall    (rsp_stall),
      .ready        (merge_ready),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data)
   );

   a_frame_end_on_line_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.frame_end || rsp_data.line_end))
      else $error("frame_end without line_end");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && rsp_valid))
      else $error("input stalled with an empty stage");

   a_output_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !v3_ff) |=> !rsp_valid)
      else $error("output word repeated");

endmodule

>>> test/tb_top.sv
// tb_top: self-checking bench for yuyv_crop_to_rgb_core, macropixel stream in, cropped rgb out
// predicts crop window, position counters and bt.601 conversion; checks every result word
// depends on ycr_pkg and yuyv_crop_to_rgb_core
`timescale 1ns / 1ps

module tb_top;
   import ycr_pkg::*;

   localparam int unsigned LINE_MAX       = 2048;
   localparam int unsigned ROW_MAX        = 4095;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          HOLD_CYCLES    = 80;
   localparam int          SETTLE_CYCLES  = 8;
   localparam int          END_CYCLES     = 10;
   localparam int          RANDOM_ITEMS   = 900;

   typedef struct packed {
      req_word_type word;
      logic         typed;
      logic         has_rsp;
      rsp_word_type rsp;
   } vector_row_type;

   localparam vector_row_type DIRECTED_VECTORS [14] = '{
      '{'{8'd16, 8'd128, 8'd16, 8'd128, 1'b1}, 1'b1, 1'b1,
        '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0}},
      '{'{8'd255, 8'd128, 8'd255, 8'd128, 1'b0}, 1'b1, 1'b1,
        '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0}},
      '{'{8'd0, 8'd128, 8'd0, 8'd128, 1'b0}, 1'b1, 1'b1,
        '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0}},
      '{'{8'd16, 8'd255, 8'd16, 8'd128, 1'b0}, 1'b1, 1'b1,
        '{8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 1'b1, 1'b1}},
      '{'{8'd16, 8'd128, 8'd16, 8'd255, 1'b0}, 1'b1, 1'b0, '0},
      '{'{8'd16, 8'd128, 8'd16, 8'd255, 1'b1}, 1'b1, 1'b1,
        '{8'd202, 8'd0, 8'd0, 8'd202, 8'd0, 8'd0, 1'b0, 1'b0}},
      '{'{8'd16, 8'd0, 8'd16, 8'd0, 1'b0}, 1'b1, 1'b1,
        '{8'd0, 8'd154, 8'd0, 8'd0, 8'd154, 8'd0, 1'b1, 1'b0}},
      '{'{8'd255, 8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, 1'b0, '0},
      '{'{8'd0, 8'd0, 8'd0, 8'd0, 1'b0}, 1'b0, 1'b0, '0},
      '{'{8'd170, 8'd85, 8'd85, 8'd170, 1'b0}, 1'b0, 1'b0, '0},
      '{'{8'd85, 8'd170, 8'd170, 8'd85, 1'b1}, 1'b0, 1'b0, '0},
      '{'{8'd235, 8'd240, 8'd16, 8'd16, 1'b0}, 1'b0, 1'b0, '0},
      '{'{8'd128, 8'd128, 8'd200, 8'd60, 1'b0}, 1'b0, 1'b0, '0},
      '{'{8'd16, 8'd128, 8'd235, 8'd128, 1'b0}, 1'b0, 1'b0, '0}
   };

   string field_names [8] = '{"red_first", "green_first", "blue_first", "red_second",
                              "green_second", "blue_second", "line_end", "frame_end"};

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_word_type        req_data  = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_word_type        rsp_data;
   logic                psel      = 1'b0;
   logic                penable   = 1'b0;
   logic                pwrite    = 1'b0;
   logic [ADDR_W-1:0]   paddr     = '0;
   logic [31:0]         pwdata    = '0;
   logic [31:0]         prdata;
   logic                pready;

   int unsigned win_fw   = RST_FRAME_WIDTH;
   int unsigned win_left = RST_CROP_LEFT;
   int unsigned win_top  = RST_CROP_TOP;
   int unsigned win_cw   = RST_CROP_WIDTH;
   int unsigned win_ch   = RST_CROP_HEIGHT;
   logic [10:0] col_pos  = '0;
   logic [11:0] row_pos  = '0;

   rsp_word_type pixel_queue [$];
   int unsigned  failures       = 0;
   int unsigned  sent_total     = 0;
   int           send_idle_pct  = 0;
   int           recv_idle_pct  = 0;
   logic         hold_ask       = 1'b0;
   logic         hold_seen      = 1'b0;
   int           hold_left      = 0;
   int           quiet_cycles   = 0;

   yuyv_crop_to_rgb_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #1 clock = ~clock;

   function automatic logic [7:0] clamp_chan(input int sum);
      int c;
      c = (sum < 999) ? 999 : sum;
      c = c / 1000;
      if (c > 255) c = 255;
      return c[7:0];
   endfunction

   function automatic bit convert_macropixel(input req_word_type w, output rsp_word_type px);
      int unsigned per_line, col, row, x, lft, rgt;
      int y0, y1, u, v;
      bit last, kept, lend;
      per_line = win_fw >> 1;
      if (per_line > LINE_MAX) per_line = LINE_MAX;
      if (per_line < 1) per_line = 1;
      if (w.frame_start) begin
         col_pos = '0;
         row_pos = '0;
      end
      col = col_pos;
      row = row_pos;
      if (col >= per_line) col = per_line - 1;
      last = (col == per_line - 1);
      x = col * 2;
      lft = win_left & ~32'd1;
      rgt = lft + (win_cw & ~32'd1);
      kept = row >= win_top && row < win_top + win_ch && x >= lft && x + 2 <= rgt;
      px = '0;
      if (kept) begin
         y0 = int'(w.luma_first) - 16;
         y1 = int'(w.luma_second) - 16;
         u = int'(w.chroma_blue) - 128;
         v = int'(w.chroma_red) - 128;
         lend = (x + 2 == rgt) || last;
         px.red_first    = clamp_chan(1164 * y0 + 1596 * v);
         px.green_first  = clamp_chan(1164 * y0 - 392 * u - 813 * v);
         px.blue_first   = clamp_chan(1164 * y0 + 2017 * u);
         px.red_second   = clamp_chan(1164 * y1 + 1596 * v);
         px.green_second = clamp_chan(1164 * y1 - 392 * u - 813 * v);
         px.blue_second  = clamp_chan(1164 * y1 + 2017 * u);
         px.line_end     = lend;
         px.frame_end    = lend && (row == win_top + win_ch - 1);
      end
      if (last) begin
         col_pos = '0;
         if (row < ROW_MAX) row_pos = 12'(row + 1);
      end else begin
         col_pos = 11'(col + 1);
      end
      return kept;
   endfunction

   function automatic logic [7:0] field_of(input rsp_word_type w, input int i);
      case (i)
         0: return w.red_first;
         1: return w.green_first;
         2: return w.blue_first;
         3: return w.red_second;
         4: return w.green_second;
         5: return w.blue_second;
         6: return {7'd0, w.line_end};
         default: return {7'd0, w.frame_end};
      endcase
   endfunction

   function automatic logic [31:0] shadow_of(input reg_index_type idx);
      case (idx)
         REG_FRAME_WIDTH: return win_fw;
         REG_CROP_LEFT:   return win_left;
         REG_CROP_TOP:    return win_top;
         REG_CROP_WIDTH:  return win_cw;
         default:         return win_ch;
      endcase
   endfunction

   function automatic req_word_type rand_word(input bit fs);
      return req_word_type'({$urandom, fs});
   endfunction

   task automatic check_pixels(input rsp_word_type got);
      rsp_word_type want;
      if (pixel_queue.size() == 0) begin
         $error("result word with nothing pending");
         failures++;
         return;
      end
      want = pixel_queue.pop_front();
      for (int i = 0; i < 8; i++) begin
         if (field_of(want, i) !== field_of(got, i)) begin
            $error("%s: expected %0d, actual %0d", field_names[i], field_of(want, i),
                   field_of(got, i));
            failures++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_pixels(rsp_data);
         if (hold_ask != hold_seen) begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic csr_access(input bit wr, input reg_index_type idx, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= {idx, 2'b00};
      pwdata <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_reg(input reg_index_type idx);
      logic [31:0] rd;
      csr_access(1'b0, idx, '0, rd);
      if (rd !== shadow_of(idx)) begin
         $error("%s: expected %0d, actual %0d", idx.name(), shadow_of(idx), rd);
         failures++;
      end
   endtask

   task automatic set_reg(input reg_index_type idx, input logic [31:0] value);
      logic [31:0] rd;
      csr_access(1'b1, idx, value, rd);
      case (idx)
         REG_FRAME_WIDTH: win_fw   = value & 32'h1fff;
         REG_CROP_LEFT:   win_left = value & 32'h0fff;
         REG_CROP_TOP:    win_top  = value & 32'h0fff;
         REG_CROP_WIDTH:  win_cw   = value & 32'h1fff;
         default:         win_ch   = value & 32'h1fff;
      endcase
      check_reg(idx);
   endtask

   task automatic drain_and_settle;
      req_valid <= 1'b0;
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input int unsigned fw, input int unsigned lft,
                            input int unsigned top, input int unsigned cw,
                            input int unsigned ch);
      drain_and_settle();
      set_reg(REG_FRAME_WIDTH, fw);
      set_reg(REG_CROP_LEFT, lft);
      set_reg(REG_CROP_TOP, top);
      set_reg(REG_CROP_WIDTH, cw);
      set_reg(REG_CROP_HEIGHT, ch);
   endtask

   task automatic set_idle(input int sender_pct, input int receiver_pct);
      send_idle_pct <= sender_pct;
      recv_idle_pct <= receiver_pct;
   endtask

   task automatic send_word(input req_word_type w, input bit typed, input bit has_rsp,
                            input rsp_word_type typed_px);
      rsp_word_type px;
      bit           kept;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      sent_total++;
      kept = convert_macropixel(w, px);
      if (typed && has_rsp) pixel_queue.push_back(typed_px);
      else if (!typed && kept) pixel_queue.push_back(px);
   endtask

   initial begin
      bit          fs;
      int unsigned base_total;
      int unsigned fw, lft, top, cw, ch, per_line, count;

      set_idle(29, 52);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < 5; i++) check_reg(reg_index_type'(i));

      // two macropixels per line, two kept rows
      configure(4, 0, 0, 4, 2);
      foreach (DIRECTED_VECTORS[i])
         send_word(DIRECTED_VECTORS[i].word, DIRECTED_VECTORS[i].typed,
                   DIRECTED_VECTORS[i].has_rsp, DIRECTED_VECTORS[i].rsp);

      // receiver holds off while the sender keeps offering, every word kept
      configure(8, 0, 0, 8, 64);
      for (int n = 0; n < 40; n++) begin
         if (n == 4) hold_ask <= ~hold_ask;
         send_word(rand_word(n == 0), 1'b0, 1'b0, '0);
      end

      base_total = sent_total;
      while (sent_total - base_total < RANDOM_ITEMS) begin
         if (sent_total - base_total >= 2 * RANDOM_ITEMS / 3) set_idle(0, 0);
         else if (sent_total - base_total >= RANDOM_ITEMS / 3) set_idle(52, 29);
         fw = $urandom_range(40);
         lft = $urandom_range(fw + 4);
         top = $urandom_range(4);
         cw = $urandom_range(fw + 6);
         ch = $urandom_range(6);
         configure(fw, lft, top, cw, ch);
         per_line = (fw >> 1 == 0) ? 1 : fw >> 1;
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(9) == 0) begin
               repeat ($urandom_range(1, 30)) begin
                  if (sent_total - base_total < RANDOM_ITEMS)
                     send_word(rand_word($urandom_range(7) == 0), 1'b0, 1'b0, '0);
               end
            end else begin
               count = (top + ch + $urandom_range(2)) * per_line + 1;
               if ($urandom_range(7) == 0) count = $urandom_range(1, count);
               for (int n = 0; n < count && sent_total - base_total < RANDOM_ITEMS; n++) begin
                  fs = (n == 0 && $urandom_range(5) != 0) || $urandom_range(49) == 0;
                  send_word(rand_word(fs), 1'b0, 1'b0, '0);
               end
            end
         end
      end

      req_valid <= 1'b0;
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
